>>> rtl/ptbm_pkg.sv
`timescale 1ns / 1ps

package ptbm_pkg;

  localparam int CP_W     = 21;
  localparam int LEN_W    = 3;
  localparam int CLASS_W  = 3;
  localparam int COUNT_W  = 4;
  localparam int DIGIT_W  = 4;
  localparam int CONTR_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int RES_DEPTH  = 4;

  localparam logic [CLASS_W-1:0] CLS_LETTER = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_DIGIT  = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_SPACE  = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_APOS   = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_OTHER  = 3'd4;

  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_LETTER   = 3'd1;
  localparam logic [2:0] MODE_DIGIT    = 3'd2;
  localparam logic [2:0] MODE_SPACE    = 3'd3;
  localparam logic [2:0] MODE_CONTRACT = 3'd4;
  localparam logic [2:0] MODE_SYMBOL   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIGIT_RUN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CONTRACT  = 1'd1;

  localparam logic [DIGIT_W-1:0] MAX_DIGIT_RESET    = 4'd3;
  localparam logic [CONTR_W-1:0] MAX_CONTRACT_RESET = 2'd2;
  localparam logic [COUNT_W-1:0] COUNT_SAT          = 4'd15;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] byte_length;
    logic             starts_piece;
    logic             text_done;
    logic             last_result;
  } result_t;

endpackage

>>> rtl/pretoken_boundary_marker_core.sv
`timescale 1ns / 1ps

// Pre-token boundary marker. Takes one classified code point per request and
// releases it one request later with a piece-start flag; a valid end-of-text
// request releases both the held character and itself. Requests are taken one
// per cycle while the four-entry result queue has room for two more results, so
// the sustained rate is one character per cycle with a ready output; the
// queue lets the input side run while a result waits on out_ready. Results
// are written to the registered queue when released and leave it in order. Invalid bytes
// are dropped and close any open run. Configuration writes take effect at
// once and are meant for idle periods only.
module pretoken_boundary_marker_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ptbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptbm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ptbm_pkg::CLASS_W-1:0]      in_char_class,
  input  logic [ptbm_pkg::CP_W-1:0]         in_code_point,
  input  logic [ptbm_pkg::LEN_W-1:0]        in_byte_length,
  input  logic                              in_end_of_text,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ptbm_pkg::CP_W-1:0]         out_code_point,
  output logic [ptbm_pkg::LEN_W-1:0]        out_byte_length,
  output logic                              out_starts_piece,
  output logic                              out_text_done,
  output logic                              out_last_result
);

  import ptbm_pkg::*;

  localparam int RES_Q_DEPTH = RES_DEPTH;
  localparam int PTR_W = (RES_Q_DEPTH > 1) ? $clog2(RES_Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(RES_Q_DEPTH + 1);
  localparam logic [CNT_W-1:0] READY_LIMIT = CNT_W'(RES_Q_DEPTH - 2);

  logic [DIGIT_W-1:0] max_digit_r;
  logic [CONTR_W-1:0] max_contr_r;

  logic [CP_W-1:0]    held_cp_r,    held_cp_nxt;
  logic [LEN_W-1:0]   held_len_r,   held_len_nxt;
  logic [CLASS_W-1:0] held_class_r, held_class_nxt;
  logic               held_valid_r, held_valid_nxt;
  logic               held_starts_r, held_starts_nxt;
  logic [2:0]         run_mode_r,   run_mode_nxt;
  logic [COUNT_W-1:0] run_count_r,  run_count_nxt;

  result_t            res_q_r [RES_Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r,  count_nxt;

  logic               in_acc;
  logic               out_acc;
  logic               cls_ok;
  logic               push_held;
  logic               push_cur;
  result_t            held_res;
  result_t            cur_res;
  logic               cur_starts;
  logic [2:0]         cls_mode;
  logic [COUNT_W-1:0] cls_count;
  logic [COUNT_W-1:0] count_bump;
  logic [PTR_W-1:0]   cur_ptr;
  result_t            head;

  assign in_ready = (count_r <= READY_LIMIT);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign out_acc  = out_valid && out_ready;
  assign cls_ok   = (in_char_class <= CLS_OTHER);
  assign count_bump = (run_count_r < COUNT_SAT) ? run_count_r + COUNT_W'(1) : run_count_r;

  always_comb begin
    cur_starts = 1'b1;
    cls_mode   = run_mode_r;
    cls_count  = run_count_r;
    case (in_char_class)
      CLS_LETTER: begin
        if (run_mode_r == MODE_LETTER) begin
          cur_starts = 1'b0;
        end else if (run_mode_r == MODE_CONTRACT &&
                     run_count_r < COUNT_W'(max_contr_r)) begin
          cur_starts = 1'b0;
          cls_count  = count_bump;
        end else begin
          cls_mode  = MODE_LETTER;
          cls_count = COUNT_W'(1);
        end
      end
      CLS_DIGIT: begin
        if (run_mode_r == MODE_DIGIT && run_count_r < COUNT_W'(max_digit_r)) begin
          cur_starts = 1'b0;
          cls_count  = count_bump;
        end else begin
          cls_mode  = MODE_DIGIT;
          cls_count = COUNT_W'(1);
        end
      end
      CLS_SPACE: begin
        if (run_mode_r == MODE_SPACE) begin
          cur_starts = 1'b0;
          cls_count  = count_bump;
        end else begin
          cls_mode  = MODE_SPACE;
          cls_count = COUNT_W'(1);
        end
      end
      CLS_APOS: begin
        cls_mode  = MODE_CONTRACT;
        cls_count = '0;
      end
      default: begin
        cls_mode  = MODE_SYMBOL;
        cls_count = COUNT_W'(1);
      end
    endcase
  end

  always_comb begin
    held_res.code_point   = held_cp_r;
    held_res.byte_length  = held_len_r;
    held_res.starts_piece = held_starts_r ||
                            (held_class_r == CLS_SPACE && in_char_class != CLS_SPACE);
    held_res.text_done    = in_end_of_text && !cls_ok;
    held_res.last_result  = !(cls_ok && in_end_of_text);

    cur_res.code_point   = in_code_point;
    cur_res.byte_length  = in_byte_length;
    cur_res.starts_piece = cur_starts;
    cur_res.text_done    = 1'b1;
    cur_res.last_result  = 1'b1;

    push_held = in_acc && held_valid_r;
    push_cur  = in_acc && cls_ok && in_end_of_text;

    held_cp_nxt     = held_cp_r;
    held_len_nxt    = held_len_r;
    held_class_nxt  = held_class_r;
    held_starts_nxt = held_starts_r;
    held_valid_nxt  = held_valid_r;
    run_mode_nxt    = run_mode_r;
    run_count_nxt   = run_count_r;

    if (in_acc) begin
      held_valid_nxt = 1'b0;
      if (!cls_ok || in_end_of_text) begin
        run_mode_nxt  = MODE_NONE;
        run_count_nxt = '0;
      end else begin
        run_mode_nxt    = cls_mode;
        run_count_nxt   = cls_count;
        held_cp_nxt     = in_code_point;
        held_len_nxt    = in_byte_length;
        held_class_nxt  = in_char_class;
        held_starts_nxt = cur_starts;
        held_valid_nxt  = 1'b1;
      end
    end

    cur_ptr    = push_held ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_held) + PTR_W'(push_cur);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(out_acc);
    count_nxt  = count_r + CNT_W'(push_held) + CNT_W'(push_cur) - CNT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_digit_r   <= MAX_DIGIT_RESET;
      max_contr_r   <= MAX_CONTRACT_RESET;
      held_valid_r  <= 1'b0;
      held_starts_r <= 1'b0;
      held_class_r  <= '0;
      held_cp_r     <= '0;
      held_len_r    <= '0;
      run_mode_r    <= MODE_NONE;
      run_count_r   <= '0;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      count_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_DIGIT_RUN: max_digit_r <= cfg_wdata[DIGIT_W-1:0];
          REG_MAX_CONTRACT:  max_contr_r <= cfg_wdata[CONTR_W-1:0];
          default: ;
        endcase
      end
      held_valid_r  <= held_valid_nxt;
      held_starts_r <= held_starts_nxt;
      held_class_r  <= held_class_nxt;
      held_cp_r     <= held_cp_nxt;
      held_len_r    <= held_len_nxt;
      run_mode_r    <= run_mode_nxt;
      run_count_r   <= run_count_nxt;
      wr_ptr_r      <= wr_ptr_nxt;
      rd_ptr_r      <= rd_ptr_nxt;
      count_r       <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_held) begin
      res_q_r[wr_ptr_r] <= held_res;
    end
    if (push_cur) begin
      res_q_r[cur_ptr] <= cur_res;
    end
  end

  assign head             = res_q_r[rd_ptr_r];
  assign out_code_point   = head.code_point;
  assign out_byte_length  = head.byte_length;
  assign out_starts_piece = head.starts_piece;
  assign out_text_done    = head.text_done;
  assign out_last_result  = head.last_result;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ptbm_pkg::*;

  localparam logic [CLASS_W-1:0] CLS_INVALID    = 3'd5;
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN_LO = 3'd6;
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN_HI = 3'd7;
  localparam logic [CP_W-1:0]    CP_TOP         = 21'h10FFFF;
  localparam logic [CP_W-1:0]    CP_ALL_ONES    = 21'h1FFFFF;

  class piece_scoreboard;
    logic [DIGIT_W-1:0] digit_limit;
    logic [CONTR_W-1:0] contract_limit;
    logic [CP_W-1:0]    held_cp;
    logic [LEN_W-1:0]   held_len;
    logic [CLASS_W-1:0] held_cls;
    bit                 held_valid;
    bit                 held_starts;
    logic [2:0]         mode;
    logic [COUNT_W-1:0] count;
    result_t            expected_q[$];
    int                 errors;

    function new();
      digit_limit    = MAX_DIGIT_RESET;
      contract_limit = MAX_CONTRACT_RESET;
      held_cp        = '0;
      held_len       = '0;
      held_cls       = '0;
      held_valid     = 1'b0;
      held_starts    = 1'b0;
      mode           = MODE_NONE;
      count          = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_MAX_DIGIT_RUN) digit_limit = value;
      else contract_limit = value[CONTR_W-1:0];
    endfunction

    function void bump();
      if (count < COUNT_SAT) count++;
    endfunction

    function bit piece_starts(logic [CLASS_W-1:0] cls);
      case (cls)
        CLS_LETTER: begin
          if (mode == MODE_LETTER) return 1'b0;
          if (mode == MODE_CONTRACT && count < contract_limit) begin
            bump();
            return 1'b0;
          end
          mode  = MODE_LETTER;
          count = COUNT_W'(1);
          return 1'b1;
        end
        CLS_DIGIT: begin
          if (mode == MODE_DIGIT && count < digit_limit) begin
            bump();
            return 1'b0;
          end
          mode  = MODE_DIGIT;
          count = COUNT_W'(1);
          return 1'b1;
        end
        CLS_SPACE: begin
          if (mode == MODE_SPACE) begin
            bump();
            return 1'b0;
          end
          mode  = MODE_SPACE;
          count = COUNT_W'(1);
          return 1'b1;
        end
        CLS_APOS: begin
          mode  = MODE_CONTRACT;
          count = '0;
          return 1'b1;
        end
        default: begin
          mode  = MODE_SYMBOL;
          count = COUNT_W'(1);
          return 1'b1;
        end
      endcase
    endfunction

    function void note_char(logic [CLASS_W-1:0] cls, logic [CP_W-1:0] cp,
                            logic [LEN_W-1:0] len, bit eot);
      bit      known;
      bit      st;
      result_t r;
      known = (cls <= CLS_OTHER);
      if (held_valid) begin
        r.code_point   = held_cp;
        r.byte_length  = held_len;
        // a whitespace run leaves its last space as its own piece
        r.starts_piece = held_starts | (held_cls == CLS_SPACE && cls != CLS_SPACE);
        r.text_done    = eot && !known;
        r.last_result  = !(known && eot);
        expected_q.push_back(r);
        held_valid = 1'b0;
      end
      if (!known) begin
        mode  = MODE_NONE;
        count = '0;
        return;
      end
      st = piece_starts(cls);
      if (eot) begin
        r.code_point   = cp;
        r.byte_length  = len;
        r.starts_piece = st;
        r.text_done    = 1'b1;
        r.last_result  = 1'b1;
        expected_q.push_back(r);
        mode  = MODE_NONE;
        count = '0;
      end else begin
        held_cp     = cp;
        held_len    = len;
        held_cls    = cls;
        held_starts = st;
        held_valid  = 1'b1;
      end
    endfunction

    function void check_release(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result cp=%h len=%0d start=%0d done=%0d last=%0d",
                   $time, got.code_point, got.byte_length, got.starts_piece,
                   got.text_done, got.last_result);
        return;
      end
      exp = expected_q.pop_front();
      if (got.code_point !== exp.code_point || got.byte_length !== exp.byte_length ||
          got.starts_piece !== exp.starts_piece || got.text_done !== exp.text_done ||
          got.last_result !== exp.last_result) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch exp cp=%h len=%0d start=%0d done=%0d last=%0d",
                   $time, exp.code_point, exp.byte_length, exp.starts_piece,
                   exp.text_done, exp.last_result);
          $display("%0t: mismatch got cp=%h len=%0d start=%0d done=%0d last=%0d",
                   $time, got.code_point, got.byte_length, got.starts_piece,
                   got.text_done, got.last_result);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [CLASS_W-1:0]    in_char_class  = '0;
  logic [CP_W-1:0]       in_code_point  = '0;
  logic [LEN_W-1:0]      in_byte_length = '0;
  logic                  in_end_of_text = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [CP_W-1:0]       out_code_point;
  logic [LEN_W-1:0]      out_byte_length;
  logic                  out_starts_piece;
  logic                  out_text_done;
  logic                  out_last_result;

  logic                  rx_hold        = 1'b0;
  int                    tx_idle_pct    = 31;
  int                    rx_idle_pct    = 85;
  int                    chars_sent     = 0;

  piece_scoreboard sb = new();

  pretoken_boundary_marker_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_class    (in_char_class),
    .in_code_point    (in_code_point),
    .in_byte_length   (in_byte_length),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_byte_length  (out_byte_length),
    .out_starts_piece (out_starts_piece),
    .out_text_done    (out_text_done),
    .out_last_result  (out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_char(in_char_class, in_code_point, in_byte_length, in_end_of_text);
    if (rst_n && out_valid && out_ready)
      sb.check_release({out_code_point, out_byte_length, out_starts_piece,
                        out_text_done, out_last_result});
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [CP_W-1:0] rand_cp();
    return CP_W'($urandom_range(0, CP_TOP));
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    if ($urandom_range(15) == 0) return LEN_W'($urandom_range(0, 7));
    return LEN_W'($urandom_range(1, 4));
  endfunction

  task automatic send_char(input logic [CLASS_W-1:0] cls, input logic [CP_W-1:0] cp,
                           input logic [LEN_W-1:0] len, input bit eot);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_class  <= cls;
    in_code_point  <= cp;
    in_byte_length <= len;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    if (cls <= CLS_OTHER) chars_sent++;
  endtask

  task automatic send_run(input logic [CLASS_W-1:0] cls, input int n);
    for (int i = 0; i < n; i++)
      send_char(cls, rand_cp(), rand_len(), $urandom_range(99) < 2);
  endtask

  task automatic send_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) send_run(CLS_LETTER, $urandom_range(1, 8));
    else if (pick < 45) send_run(CLS_DIGIT, $urandom_range(1, 18));
    else if (pick < 63) send_run(CLS_SPACE, $urandom_range(1, 4));
    else if (pick < 76) begin
      send_run(CLS_APOS, 1);
      send_run(CLS_LETTER, $urandom_range(0, 4));
    end
    else if (pick < 86) send_run(CLS_OTHER, $urandom_range(1, 3));
    else if (pick < 92)
      send_char(CLASS_W'($urandom_range(CLS_INVALID, CLS_UNKNOWN_HI)), rand_cp(), rand_len(),
                $urandom_range(99) < 5);
    else
      send_char(CLASS_W'($urandom_range(0, 7)), CP_W'($urandom_range(0, CP_ALL_ONES)),
                LEN_W'($urandom_range(0, 7)), $urandom_range(99) < 10);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [DIGIT_W-1:0] digits,
                            input logic [CONTR_W-1:0] letters);
    logic [CFG_DATA_W-1:0] wdata;
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_DIGIT_RUN;
    cfg_wdata <= digits;
    sb.write_reg(REG_MAX_DIGIT_RUN, digits);
    @(posedge clk);
    // upper bits of the contraction write are don't-care
    wdata = {2'($urandom_range(0, 3)), letters};
    cfg_index <= REG_MAX_CONTRACT;
    cfg_wdata <= wdata;
    sb.write_reg(REG_MAX_CONTRACT, wdata);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int n);
    int goal;
    goal = chars_sent + n;
    while (chars_sent < goal) send_token();
    send_char(CLS_LETTER, rand_cp(), rand_len(), 1'b1);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: 3 digits per piece, 2 contraction letters
    send_char(CLS_LETTER, '0, 3'd1, 1'b0);
    send_char(CLS_LETTER, CP_TOP, 3'd4, 1'b0);
    send_char(CLS_APOS, 21'h27, 3'd1, 1'b0);
    send_char(CLS_LETTER, 21'h6C, 3'd1, 1'b0);
    send_char(CLS_LETTER, 21'h6C, 3'd1, 1'b0);
    send_char(CLS_LETTER, 21'h79, 3'd1, 1'b0);
    send_char(CLS_DIGIT, 21'h31, 3'd1, 1'b0);
    send_char(CLS_DIGIT, 21'h32, 3'd1, 1'b0);
    send_char(CLS_DIGIT, 21'h33, 3'd1, 1'b0);
    send_char(CLS_DIGIT, 21'h34, 3'd1, 1'b0);
    send_char(CLS_SPACE, 21'h20, 3'd1, 1'b0);
    send_char(CLS_SPACE, 21'h20, 3'd1, 1'b0);
    send_char(CLS_LETTER, 21'h41, 3'd1, 1'b0);
    send_char(CLS_SPACE, 21'h3000, 3'd3, 1'b0);
    send_char(CLS_INVALID, 21'h80, 3'd1, 1'b0);
    send_char(CLS_OTHER, CP_ALL_ONES, 3'd7, 1'b0);
    send_char(CLS_UNKNOWN_LO, 21'h1234, 3'd2, 1'b0);
    send_char(CLS_DIGIT, 21'h39, 3'd0, 1'b0);
    send_char(CLS_UNKNOWN_HI, 21'h5555, 3'd5, 1'b0);
    send_char(CLS_SPACE, 21'h0A, 3'd1, 1'b1);
    send_char(CLS_INVALID, 21'hFF, 3'd1, 1'b1);
    send_char(CLS_LETTER, 21'h7A, 3'd1, 1'b0);
    send_char(CLS_INVALID, 21'hC0, 3'd1, 1'b1);
    send_char(CLS_APOS, 21'h2019, 3'd3, 1'b0);
    send_char(CLS_OTHER, 21'h21, 3'd1, 1'b1);
    drain();

    write_regs(4'd0, 2'd0);
    run_phase(112);
    write_regs(4'd15, 2'd3);
    run_phase(112);

    tx_idle_pct = 85;
    rx_idle_pct = 31;
    write_regs(4'd1, 2'd1);
    run_phase(112);
    write_regs(4'd15, 2'd0);
    run_phase(112);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_regs(DIGIT_W'($urandom_range(1, 15)), CONTR_W'($urandom_range(1, 3)));
    fork
      run_phase(112);
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join
    drain();
    write_regs(MAX_DIGIT_RESET, MAX_CONTRACT_RESET);
    run_phase(112);

    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
